@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check clocked on clk, disabled while active-low reset is low.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/mdma_pkg.sv @@
// Package for the multiply / divide / MAC unit: request and result types,
// mode bit positions, widths and the sequencer control struct. No dependencies.
`default_nettype none

package mdma_pkg;

  localparam int unsigned OpW     = 16;
  localparam int unsigned ProdW   = 2 * OpW;
  localparam int unsigned AccHiW  = 8;
  localparam int unsigned AccW    = ProdW + AccHiW;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StepCntW = $clog2(OpW);

  // Mode register bit positions
  localparam int unsigned ModeAccBit = 1;
  localparam int unsigned ModeDivBit = 0;

  typedef struct packed {
    logic signed [OpW-1:0] operand_a;
    logic [OpW-1:0]        operand_b;
  } in_req_t;

  typedef struct packed {
    logic [ProdW-1:0]  result_low;
    logic [AccHiW-1:0] result_high;
    logic              overflow_flag;
  } out_req_t;

  // Sequencer to datapath strobes
  typedef struct packed {
    logic load;
    logic step;
    logic fixup;
    logic accum;
    logic done;
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mdma_addsub.sv @@
// Shared 17-bit add/subtract unit used by every multiply and divide step.
// Depends on mdma_pkg for the operand width.
`default_nettype none

module mdma_addsub
  import mdma_pkg::*;
(
  input  wire logic [OpW:0]   x_i,
  input  wire logic [OpW:0]   y_i,
  input  wire logic           sub_i,
  output logic      [OpW+1:0] sum_o
);

  logic [OpW:0] y_eff;

  // Subtract as x + ~y + 1; top bit then means "no borrow"
  assign y_eff = sub_i ? ~y_i : y_i;
  assign sum_o = {1'b0, x_i} + {1'b0, y_eff} + {{(OpW+1){1'b0}}, sub_i};

endmodule

`default_nettype wire

@@ rtl/mdma_ctrl.sv @@
// Sequencer for the multiply / divide / MAC unit: load, 16 shared-unit
// steps, sign fixup, optional accumulate, result handoff. Uses mdma_pkg.
`default_nettype none

module mdma_ctrl
  import mdma_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_free_i,
  input  wire logic acc_mode_i,
  output logic      in_ready_o,
  output ctrl_t     ctrl_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          cnt_d   = StepCntW'(OpW - 1);
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_FIX;
      end
      ST_FIX:  state_d = acc_mode_i ? ST_ACC : ST_DONE;
      ST_ACC:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Strobes to the datapath
  assign in_ready_o   = (state_q == ST_IDLE);
  assign ctrl_o.load  = (state_q == ST_IDLE) && in_valid_i;
  assign ctrl_o.step  = (state_q == ST_RUN);
  assign ctrl_o.fixup = (state_q == ST_FIX);
  assign ctrl_o.accum = (state_q == ST_ACC);
  assign ctrl_o.done  = (state_q == ST_DONE) && out_free_i;

endmodule

`default_nettype wire

@@ rtl/mdma_datapath.sv @@
// Datapath: operand magnitudes, shift-add multiply / restoring divide on the
// shared adder, sign fixup and 40-bit accumulator. Uses mdma_pkg, mdma_addsub.
`default_nettype none

module mdma_datapath
  import mdma_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire in_req_t          in_data_i,
  output logic [ProdW-1:0]      acc_lo_o,
  output logic [AccHiW-1:0]     acc_hi_o,
  output logic                  ovf_o
);

  logic               is_div;
  logic [OpW-1:0]     hi_q, hi_d, lo_q, lo_d, b_q;
  logic               neg_q, div_q, bzero_q;
  logic [OpW-1:0]     a_raw, b_raw, a_mag, b_mag;
  logic [OpW:0]       rem_sh, add_x, add_y;
  logic [OpW+1:0]     add_sum;
  logic               ge;
  logic [ProdW-1:0]   mag, fix_val;
  logic [OpW-1:0]     q_fix, r_fix;
  logic [AccW:0]      acc_sum;
  logic [ProdW-1:0]   acc_lo_q;
  logic [AccHiW-1:0]  acc_hi_q;
  logic               ovf_q;

  assign is_div = !mode_i[ModeAccBit] && mode_i[ModeDivBit];

  // Operand magnitudes at load; the divisor is taken unsigned
  assign a_raw = in_data_i.operand_a;
  assign b_raw = in_data_i.operand_b;
  assign a_mag = a_raw[OpW-1] ? (~a_raw + 1'b1) : a_raw;
  assign b_mag = (!is_div && b_raw[OpW-1]) ? (~b_raw + 1'b1) : b_raw;

  // Shared unit operands: add multiplicand, or trial-subtract divisor
  assign rem_sh = {hi_q, lo_q[OpW-1]};
  assign add_x  = div_q ? rem_sh : {1'b0, hi_q};
  assign add_y  = div_q ? {1'b0, b_q} : ((lo_q[0]) ? {1'b0, b_q} : '0);

  mdma_addsub u_addsub (
    .x_i   (add_x),
    .y_i   (add_y),
    .sub_i (div_q),
    .sum_o (add_sum)
  );

  assign ge = add_sum[OpW+1];

  // Sign fixup of the unsigned core result
  assign mag     = {hi_q, lo_q};
  assign q_fix   = neg_q ? (~lo_q + 1'b1) : lo_q;
  assign r_fix   = neg_q ? (~hi_q + 1'b1) : hi_q;
  always_comb begin
    if (div_q) begin
      fix_val = bzero_q ? '0 : {r_fix, q_fix};
    end else begin
      fix_val = neg_q ? (~mag + 1'b1) : mag;
    end
  end

  // Core register pair update
  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (ctrl_i.load) begin
      hi_d = '0;
      lo_d = a_mag;
    end else if (ctrl_i.step) begin
      if (div_q) begin
        hi_d = ge ? add_sum[OpW-1:0] : rem_sh[OpW-1:0];
        lo_d = {lo_q[OpW-2:0], ge};
      end else begin
        hi_d = add_sum[OpW:1];
        lo_d = {add_sum[0], lo_q[OpW-1:1]};
      end
    end else if (ctrl_i.fixup) begin
      hi_d = fix_val[ProdW-1:OpW];
      lo_d = fix_val[OpW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (ctrl_i.load) begin
      b_q     <= b_mag;
      div_q   <= is_div;
      bzero_q <= (b_raw == '0);
      neg_q   <= is_div ? a_raw[OpW-1] : (a_raw[OpW-1] ^ b_raw[OpW-1]);
    end
  end

  // 40-bit accumulate with one guard bit for overflow
  assign acc_sum = {acc_hi_q[AccHiW-1], acc_hi_q, acc_lo_q}
                 + {{(AccHiW+1){hi_q[OpW-1]}}, hi_q, lo_q};

  // Architectural accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
      ovf_q    <= 1'b0;
    end else if (ctrl_i.fixup && !mode_i[ModeAccBit]) begin
      acc_lo_q <= fix_val;
    end else if (ctrl_i.accum) begin
      acc_lo_q <= acc_sum[ProdW-1:0];
      acc_hi_q <= acc_sum[AccW-1:ProdW];
      ovf_q    <= acc_sum[AccW] ^ acc_sum[AccW-1];
    end
  end

  assign acc_lo_o = acc_lo_q;
  assign acc_hi_o = acc_hi_q;
  assign ovf_o    = ovf_q;

endmodule

`default_nettype wire

@@ rtl/mul_div_mac_arith_unit.sv @@
// Signed 16x16 multiply, 16/16 divide and multiply-accumulate into a 40-bit
// accumulator.
//
// Channels: in_data_i carries operand_a (signed) and operand_b; a request is
// taken when in_valid_i and in_ready_o are both high. out_data_o returns the
// accumulator low word, high byte and overflow flag after the operation, one
// result per request, handed over on out_valid_o and out_ready_i.
// cfg_we_i / cfg_wdata_i write the 2-bit mode (bit1 accumulate, else bit0
// divide, else multiply); write it only while the unit is idle.
//
// Sequence: the accept edge loads the operands, then 16 steps of the shared
// 17-bit add/subtract unit (one shift-add or one restoring-divide step each),
// a sign fixup state, an accumulate state in MAC mode and a handoff state,
// after which out_valid_o rises. in_ready_o is high only while the sequencer
// is idle, so a new request is taken only after the last one has left the
// handoff state.
// A result waiting in the output register does not block a new request; the
// handoff cycle stretches while the receiver stalls with a result still held.
// Reset clears the mode, the accumulator, the flag and all control state.
// Depends on mdma_pkg, mdma_ctrl, mdma_datapath, mdma_addsub, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mul_div_mac_arith_unit
  import mdma_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ModeW-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_req_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_req_t              out_data_o
);

  logic [ModeW-1:0]  mode_q;
  ctrl_t             ctrl;
  logic              out_valid_q;
  out_req_t          out_data_q;
  logic              out_free;
  logic [ProdW-1:0]  acc_lo;
  logic [AccHiW-1:0] acc_hi;
  logic              ovf;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  mdma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .acc_mode_i (mode_q[ModeAccBit]),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  mdma_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .mode_i    (mode_q),
    .in_data_i (in_data_i),
    .acc_lo_o  (acc_lo),
    .acc_hi_o  (acc_hi),
    .ovf_o     (ovf)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      out_data_q.result_low    <= acc_lo;
      out_data_q.result_high   <= acc_hi;
      out_data_q.overflow_flag <= ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `ASSERT_IMPL(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `ASSERT_IMPL(a_ovf_only_on_mac, clk_i, rst_ni, !$stable(ovf) |-> $past(ctrl.accum))
  `ASSERT_IMPL(a_result_from_seq, clk_i, rst_ni, $rose(out_valid_o) |-> $past(ctrl.done))
  `ASSERT_NEVER(a_no_load_while_done, clk_i, rst_ni, ctrl.load && ctrl.done)

endmodule

`default_nettype wire
